// File: src/huffman_bit_packer_core_assert.svh
// Assertion macros for the Huffman bit packer.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH

// General property, checked on every rising clock edge outside reset.
`define HBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define HBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: src/hbp_pkg.sv
// Shared types and constants for the Huffman bit packer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

  localparam int BYTE_W          = 8;
  localparam int CODE_FIELD_W    = 32;
  localparam int LEN_W           = 6;
  localparam int SYM_W           = 8;
  localparam int WORD_W          = BYTE_W + CODE_FIELD_W;
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;
  localparam int DEF_QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    FN_LOAD   = 2'd0,
    FN_ENCODE = 2'd1,
    FN_FLUSH  = 2'd2
  } func_e;

  // One unit of work handed from the lookup front end to the packer.
  typedef struct packed {
    logic                    flush;
    logic [CODE_FIELD_W-1:0] code;
    logic [LEN_W-1:0]        len;
  } hbp_item_t;

endpackage

`default_nettype wire

// File: src/hbp_front.sv
// Front end: accepts input transfers, owns the code table memory and
// turns encode and flush requests into packer work items. Uses hbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbp_front #(
  parameter int MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       func_i,
  input  wire logic [hbp_pkg::SYM_W-1:0]        symbol_i,
  input  wire logic [hbp_pkg::CODE_FIELD_W-1:0] code_bits_i,
  input  wire logic [hbp_pkg::LEN_W-1:0]        code_length_i,
  output logic                                  item_valid_o,
  input  wire logic                             item_ready_i,
  output hbp_pkg::hbp_item_t                    item_o
);

  localparam int CAP   = (MAX_CODE_LEN > hbp_pkg::CODE_FIELD_W) ?
                         hbp_pkg::CODE_FIELD_W : MAX_CODE_LEN;
  localparam int IDX_W = $clog2(SYMBOL_COUNT);
  localparam int ENT_W = hbp_pkg::LEN_W + CAP;

  logic [ENT_W-1:0]            table_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]     ent_vld_q;
  logic [ENT_W-1:0]            rd_data_q;
  logic                        rd_vld_q;
  logic                        st_vld_q, st_vld_d;
  logic                        st_flush_q;

  logic                        accept;
  logic                        in_range;
  logic                        wr_en;
  logic                        rd_en;
  logic                        stage_take;
  logic [IDX_W-1:0]            idx;
  logic [hbp_pkg::LEN_W-1:0]   len_cap;
  logic [CAP-1:0]              code_masked;
  logic [hbp_pkg::LEN_W-1:0]   rd_len;
  logic [CAP-1:0]              rd_code;
  logic                        st_work;
  logic                        st_free;

  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = {1'b0, symbol_i} < (hbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
  assign idx        = symbol_i[IDX_W-1:0];
  assign wr_en      = accept && (func_i == hbp_pkg::FN_LOAD) && in_range;
  assign rd_en      = accept && (func_i == hbp_pkg::FN_ENCODE) && in_range;
  assign stage_take = rd_en || (accept && (func_i == hbp_pkg::FN_FLUSH));

  // Lengths saturate at the table's code width; bits above the length are dropped.
  assign len_cap     = (code_length_i > hbp_pkg::LEN_W'(CAP)) ?
                       hbp_pkg::LEN_W'(CAP) : code_length_i;
  assign code_masked = code_bits_i[CAP-1:0] & ~({CAP{1'b1}} << len_cap);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[idx] <= {len_cap, code_masked};
    end
    if (rd_en) begin
      rd_data_q <= table_mem[idx];
      rd_vld_q  <= ent_vld_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (wr_en) begin
      ent_vld_q[idx] <= 1'b1;
    end
  end

  assign rd_len  = rd_data_q[ENT_W-1:CAP];
  assign rd_code = rd_data_q[CAP-1:0];

  // An encode of an empty or never-loaded entry leaves the stage without work.
  assign st_work      = st_flush_q || (rd_vld_q && (rd_len != '0));
  assign item_valid_o = st_vld_q && st_work;
  assign st_free      = !st_vld_q || !st_work || item_ready_i;
  assign in_ready_o   = st_free;

  assign item_o.flush = st_flush_q;
  assign item_o.code  = st_flush_q ? '0 : hbp_pkg::CODE_FIELD_W'(rd_code);
  assign item_o.len   = st_flush_q ? '0 : rd_len;

  always_comb begin
    st_vld_d = st_vld_q;
    if (accept) begin
      st_vld_d = stage_take;
    end else if (st_free) begin
      st_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= st_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_take) begin
      st_flush_q <= (func_i == hbp_pkg::FN_FLUSH);
    end
  end

endmodule

`default_nettype wire

// File: src/hbp_fifo.sv
// Short work queue between the lookup front end and the packer.
// Uses hbp_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module hbp_fifo #(
  parameter int DEPTH = hbp_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire hbp_pkg::hbp_item_t    in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output hbp_pkg::hbp_item_t         out_item_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hbp_pkg::hbp_item_t slots_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   level_q;
  logic               push, pop;

  assign in_ready_o  = (level_q != CNT_W'(DEPTH));
  assign out_valid_o = (level_q != '0);
  assign out_item_o  = slots_q[rd_ptr_q];
  assign level_o     = level_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        level_q <= level_q + CNT_W'(1);
      end else if (pop && !push) begin
        level_q <= level_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/hbp_back.sv
// Packer: appends code bits MSB-first into a byte accumulator and sends one
// byte per cycle through a registered output when it is not stalled. Uses hbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       item_valid_i,
  output logic                            item_ready_o,
  input  wire hbp_pkg::hbp_item_t         item_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [hbp_pkg::BYTE_W-1:0]      out_byte_o,
  output logic                            last_o
);

  localparam int BW = hbp_pkg::BYTE_W;
  localparam int WW = hbp_pkg::WORD_W;
  localparam int TW = hbp_pkg::LEN_W;

  // Pending bits are kept left-aligned in p_q, c_q of them valid.
  logic [BW-1:0] p_q, p_d;
  logic [2:0]    c_q, c_d;
  logic          busy_q, busy_d;
  logic [WW-1:0] w_q, w_d;
  logic [TW-1:0] tot_q, tot_d;
  logic          ov_q, ov_d;
  logic [BW-1:0] ob_q, ob_d;
  logic          ol_q, ol_d;

  logic          out_free;
  logic [TW-1:0] sh;
  logic [WW-1:0] w_new;
  logic [TW-1:0] tot_new;
  logic [WW-1:0] src_w;
  logic [TW-1:0] src_tot;
  logic [TW-1:0] rem;
  logic          pop;

  assign out_free = !ov_q || out_ready_i;

  // The new code lands directly below the pending bits.
  assign sh      = TW'(WW) - TW'(c_q) - item_i.len;
  assign w_new   = {p_q, {(WW-BW){1'b0}}} | (WW'(item_i.code) << sh);
  assign tot_new = TW'(c_q) + item_i.len;
  assign src_w   = busy_q ? w_q : w_new;
  assign src_tot = busy_q ? tot_q : tot_new;
  assign rem     = src_tot - TW'(BW);

  always_comb begin
    p_d    = p_q;
    c_d    = c_q;
    busy_d = busy_q;
    w_d    = w_q;
    tot_d  = tot_q;
    ov_d   = ov_q && !out_ready_i;
    ob_d   = ob_q;
    ol_d   = ol_q;
    pop    = 1'b0;
    if (busy_q || (item_valid_i && !item_i.flush && (tot_new >= TW'(BW)))) begin
      // Send the top byte of the working word.
      if (out_free) begin
        pop    = !busy_q;
        ov_d   = 1'b1;
        ob_d   = src_w[WW-1 -: BW];
        ol_d   = (rem < TW'(BW));
        w_d    = src_w << BW;
        tot_d  = rem;
        busy_d = (rem >= TW'(BW));
        if (rem < TW'(BW)) begin
          p_d = src_w[WW-BW-1 -: BW];
          c_d = rem[2:0];
        end
      end
    end else if (item_valid_i && !item_i.flush) begin
      // Too few bits for a byte: just collect them.
      pop = 1'b1;
      p_d = w_new[WW-1 -: BW];
      c_d = tot_new[2:0];
    end else if (item_valid_i) begin
      if (c_q == '0) begin
        pop = 1'b1;
      end else if (out_free) begin
        pop  = 1'b1;
        ov_d = 1'b1;
        ob_d = p_q;
        ol_d = 1'b1;
        p_d  = '0;
        c_d  = '0;
      end
    end
  end

  assign item_ready_o = pop;
  assign out_valid_o  = ov_q;
  assign out_byte_o   = ob_q;
  assign last_o       = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= '0;
      c_q    <= '0;
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      p_q    <= p_d;
      c_q    <= c_d;
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    tot_q <= tot_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

endmodule

`default_nettype wire

// File: src/huffman_bit_packer_core.sv
// Huffman bit packer top level: front end with code table, work queue and
// packer. Uses hbp_pkg, hbp_front, hbp_fifo, hbp_back and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_bit_packer_core_assert.svh"

// Byte-wise Huffman encoder. A load (func 0) writes a code and its length into
// the table entry picked by symbol; an encode (func 1) appends that entry's
// code MSB-first and sends every completed byte; a flush (func 2) sends the
// pending partial byte padded with zeros and marks it last. The table comes
// out of reset empty, so it is usable at once, and each entry becomes valid
// when loaded. The input side takes one transfer per cycle while the work
// queue has room; loads finish in the cycle they are accepted. The table read
// is registered, so an encode passes the front end's read stage before it
// enters the work queue, and its first byte then goes through the queue and
// the packer's output register. The packer sends one byte per cycle through
// that register while the output is not stalled, and takes no new item until
// every byte of the last one is sent; a 32-bit code completes at most four bytes.
module huffman_bit_packer_core #(
  parameter int MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT,
  parameter int QUEUE_DEPTH  = hbp_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       func_i,
  input  wire logic [hbp_pkg::SYM_W-1:0]        symbol_i,
  input  wire logic [hbp_pkg::CODE_FIELD_W-1:0] code_bits_i,
  input  wire logic [hbp_pkg::LEN_W-1:0]        code_length_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [hbp_pkg::BYTE_W-1:0]            out_byte_o,
  output logic                                  last_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hbp_pkg::hbp_item_t f_item;
  hbp_pkg::hbp_item_t q_item;
  logic               f_valid;
  logic               f_ready;
  logic               q_valid;
  logic               q_pop;
  logic [CNT_W-1:0]   q_level;

  hbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .symbol_i     (symbol_i),
    .code_bits_i  (code_bits_i),
    .code_length_i(code_length_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  hbp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_item_i  (f_item),
    .out_valid_o(q_valid),
    .out_ready_i(q_pop),
    .out_item_o (q_item),
    .level_o    (q_level)
  );

  hbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_ready_o(q_pop),
    .item_i      (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  `HBP_ASSERT_NEVER(a_pop_empty, q_pop && !q_valid, "packer took from an empty queue")
  `HBP_ASSERT(a_stage_hold, f_valid && !f_ready |=> f_valid && $stable(f_item), "front item lost")
  `HBP_ASSERT(a_stall_cause, !in_ready_o |-> f_valid && !f_ready, "input stalled without cause")
  `HBP_ASSERT(a_level_bound, q_level <= CNT_W'(QUEUE_DEPTH), "queue level out of range")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for huffman_bit_packer_core: table loads, encodes and flushes.
// A shadow encoder inside the bench predicts every packed byte. Depends on hbp_pkg and the core.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT;
  localparam int LEN_CAP = (hbp_pkg::DEF_MAX_CODE_LEN < hbp_pkg::CODE_FIELD_W) ?
                           hbp_pkg::DEF_MAX_CODE_LEN : hbp_pkg::CODE_FIELD_W;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [hbp_pkg::BYTE_W-1:0] data;
    logic                       last;
  } packed_byte_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [1:0]                       func = hbp_pkg::FN_LOAD;
  logic [hbp_pkg::SYM_W-1:0]        symbol = '0;
  logic [hbp_pkg::CODE_FIELD_W-1:0] code_bits = '0;
  logic [hbp_pkg::LEN_W-1:0]        code_length = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [hbp_pkg::BYTE_W-1:0]       out_byte;
  logic                             last;

  // Shadow copy of the encoder state.
  logic [hbp_pkg::CODE_FIELD_W-1:0] shadow_code [SYMBOL_COUNT];
  logic [hbp_pkg::LEN_W-1:0]        shadow_len [SYMBOL_COUNT];
  logic [6:0]                       shadow_acc;
  logic [2:0]                       shadow_cnt;

  packed_byte_t                     packed_bytes_due[$];
  logic [hbp_pkg::SYM_W-1:0]        loaded_symbols[$];
  int                               err_count = 0;
  int                               sender_idle_pct = 0;
  int                               sink_stall_pct = 0;
  int                               quiet_cycles = 0;

  huffman_bit_packer_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (func),
    .symbol_i     (symbol),
    .code_bits_i  (code_bits),
    .code_length_i(code_length),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .last_o       (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("tb_top: mismatch at %0t: %s", $time, what);
  endtask

  // Applies one accepted transfer to the shadow state and queues the bytes it produces.
  task automatic update_shadow_encoder(input logic [1:0] fn,
                                       input logic [hbp_pkg::SYM_W-1:0] sym,
                                       input logic [hbp_pkg::CODE_FIELD_W-1:0] code,
                                       input logic [hbp_pkg::LEN_W-1:0] len);
    logic [63:0]  acc;
    int unsigned  total;
    int unsigned  len_kept;
    int unsigned  n;
    packed_byte_t b;
    case (fn)
      hbp_pkg::FN_LOAD: begin
        if (sym < SYMBOL_COUNT) begin
          len_kept = (len > LEN_CAP) ? LEN_CAP : len;
          shadow_len[sym] = hbp_pkg::LEN_W'(len_kept);
          shadow_code[sym] = hbp_pkg::CODE_FIELD_W'(64'(code) & ((64'd1 << len_kept) - 64'd1));
        end
      end
      hbp_pkg::FN_ENCODE: begin
        if (sym < SYMBOL_COUNT && shadow_len[sym] != '0) begin
          acc = (64'(shadow_acc) << shadow_len[sym]) | 64'(shadow_code[sym]);
          total = shadow_cnt + shadow_len[sym];
          n = 0;
          while (total >= 8 && n < 4) begin
            total -= 8;
            n++;
            b.data = hbp_pkg::BYTE_W'(acc >> total);
            b.last = (total < 8) || (n == 4);
            packed_bytes_due.insert(packed_bytes_due.size(), b);
          end
          shadow_cnt = 3'(total);
          shadow_acc = 7'(acc) & 7'((8'd1 << shadow_cnt) - 8'd1);
        end
      end
      hbp_pkg::FN_FLUSH: begin
        if (shadow_cnt != '0) begin
          b.data = hbp_pkg::BYTE_W'(16'(shadow_acc) << (8 - shadow_cnt));
          b.last = 1'b1;
          packed_bytes_due.insert(packed_bytes_due.size(), b);
          shadow_acc = '0;
          shadow_cnt = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Presents one item, holds it until the transfer, then updates the prediction.
  task automatic send_item(input logic [1:0] fn, input logic [hbp_pkg::SYM_W-1:0] sym,
                           input logic [hbp_pkg::CODE_FIELD_W-1:0] code,
                           input logic [hbp_pkg::LEN_W-1:0] len);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    symbol <= sym;
    code_bits <= code;
    code_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    update_shadow_encoder(fn, sym, code, len);
  endtask

  task automatic load_code(input logic [hbp_pkg::SYM_W-1:0] sym,
                           input logic [hbp_pkg::CODE_FIELD_W-1:0] code,
                           input logic [hbp_pkg::LEN_W-1:0] len);
    send_item(hbp_pkg::FN_LOAD, sym, code, len);
  endtask

  task automatic encode_symbol(input logic [hbp_pkg::SYM_W-1:0] sym);
    send_item(hbp_pkg::FN_ENCODE, sym, $urandom, hbp_pkg::LEN_W'($urandom));
  endtask

  task automatic flush_partial();
    send_item(hbp_pkg::FN_FLUSH, hbp_pkg::SYM_W'($urandom), $urandom,
              hbp_pkg::LEN_W'($urandom));
  endtask

  task automatic set_idling(input int sender_pct, input int sink_pct);
    sender_idle_pct = sender_pct;
    sink_stall_pct = sink_pct;
  endtask

  // Byte-aligned and short codes, with upper code bits that must be masked off.
  task automatic test_basic_packing();
    flush_partial();
    load_code(8'h41, 32'h0000_00A5, 6'd8);
    encode_symbol(8'h41);
    load_code(8'h42, 32'hFFFF_FFF5, 6'd3);
    encode_symbol(8'h42);
    encode_symbol(8'h42);
    encode_symbol(8'h42);
    flush_partial();
  endtask

  // Full-width codes on top of seven pending bits give four bytes; long lengths saturate.
  task automatic test_long_codes();
    load_code(8'hFF, 32'hFFFF_FFFF, 6'd32);
    load_code(8'h00, 32'h1234_5678, 6'd63);
    load_code(8'h01, 32'h8000_0001, 6'd33);
    load_code(8'h02, 32'h0000_007F, 6'd7);
    encode_symbol(8'h02);
    encode_symbol(8'hFF);
    encode_symbol(8'h00);
    encode_symbol(8'h01);
    flush_partial();
  endtask

  // Empty codes, never-loaded entries, the unused function code and a flush with nothing left.
  task automatic test_empty_and_ignored();
    encode_symbol(8'h80);
    load_code(8'h41, 32'hFFFF_FFFF, 6'd0);
    encode_symbol(8'h41);
    send_item(FN_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    flush_partial();
  endtask

  // An encode right behind the load of the same entry must see the new code.
  task automatic test_load_then_encode();
    load_code(8'h10, 32'h0000_001F, 6'd5);
    encode_symbol(8'h10);
    load_code(8'h10, 32'h0000_0ABC, 6'd12);
    encode_symbol(8'h10);
    flush_partial();
  endtask

  // Mostly encodes of loaded entries, with fresh loads, flushes and some noise.
  task automatic test_random_stream(input int item_count);
    int                        sent;
    int                        pick;
    logic [hbp_pkg::SYM_W-1:0] sym;
    logic [hbp_pkg::LEN_W-1:0] len;
    sent = 0;
    while (sent < item_count) begin
      pick = $urandom_range(99);
      if (loaded_symbols.size() < 4 || pick < 20) begin
        sym = hbp_pkg::SYM_W'($urandom);
        case ($urandom_range(9))
          0: len = '0;
          1: len = hbp_pkg::LEN_W'($urandom_range(33, 63));
          2: len = 6'd32;
          3, 4: len = hbp_pkg::LEN_W'($urandom_range(13, 31));
          default: len = hbp_pkg::LEN_W'($urandom_range(1, 12));
        endcase
        load_code(sym, $urandom, len);
        if (len != '0) begin
          loaded_symbols.insert(loaded_symbols.size(), sym);
        end
        sent++;
      end else if (pick < 80) begin
        if ($urandom_range(9) != 0) begin
          sym = loaded_symbols[$urandom_range(loaded_symbols.size() - 1)];
        end else begin
          sym = hbp_pkg::SYM_W'($urandom);
        end
        encode_symbol(sym);
        sent++;
      end else if (pick < 95) begin
        flush_partial();
        sent++;
      end else begin
        send_item(FN_UNUSED, hbp_pkg::SYM_W'($urandom), $urandom,
                  hbp_pkg::LEN_W'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin : check_output
    packed_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (packed_bytes_due.size() == 0) begin
        report_mismatch($sformatf("byte %02h last %0b with nothing expected", out_byte, last));
      end else begin
        want = packed_bytes_due[0];
        packed_bytes_due.delete(0);
        if (out_byte !== want.data) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Ends the run if neither side completes a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      shadow_code[i] = '0;
      shadow_len[i] = '0;
    end
    shadow_acc = '0;
    shadow_cnt = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(37, 81);
    test_basic_packing();
    test_long_codes();
    test_empty_and_ignored();
    test_load_then_encode();
    test_random_stream(31);
    set_idling(81, 37);
    test_random_stream(31);
    set_idling(0, 0);
    test_random_stream(31);

    in_valid <= 1'b0;
    while (packed_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
